// File: rtl/lbh_pkg.sv
`timescale 1ns / 1ps

package lbh_pkg;

    // Field widths and store depth
    localparam int MAX_BUCKETS = 120;
    localparam int IDX_W       = 7;
    localparam int DATA_W      = 64;
    localparam int CFG_IDX_W   = 2;

    // Queue between front and back; depth is a power of two so pointers wrap
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LIMIT = 2'd2;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Settings the front end needs to pick a bucket
    typedef struct packed {
        logic             log_mode;
        logic [IDX_W-1:0] bucket_count;
    } t_cfg;

    // Classified item passed from front to back; bucket holds the read index
    // for a read item
    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  bucket;
        logic [DATA_W-1:0] sample;
    } t_op;

    // Decade-tenth thresholds, entry k is floor(10^(k/10)) for k of ten and up
    localparam logic [DATA_W-1:0] THRESHOLDS [0:MAX_BUCKETS] = '{
        64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7, 64'd8, 64'd9,
        64'd10, 64'd12, 64'd15, 64'd19, 64'd25, 64'd31, 64'd39, 64'd50, 64'd63,
        64'd79, 64'd100, 64'd125, 64'd158, 64'd199, 64'd251, 64'd316, 64'd398,
        64'd501, 64'd630, 64'd794, 64'd1000, 64'd1258, 64'd1584, 64'd1995,
        64'd2511, 64'd3162, 64'd3981, 64'd5011, 64'd6309, 64'd7943, 64'd10000,
        64'd12589, 64'd15848, 64'd19952, 64'd25118, 64'd31622, 64'd39810,
        64'd50118, 64'd63095, 64'd79432, 64'd100000,
        64'd125892, 64'd158489, 64'd199526, 64'd251188, 64'd316227, 64'd398107,
        64'd501187, 64'd630957, 64'd794328, 64'd1000000,
        64'd1258925, 64'd1584893, 64'd1995262, 64'd2511886, 64'd3162277,
        64'd3981071, 64'd5011872, 64'd6309573, 64'd7943282, 64'd10000000,
        64'd12589254, 64'd15848931, 64'd19952623, 64'd25118864, 64'd31622776,
        64'd39810717, 64'd50118723, 64'd63095734, 64'd79432823, 64'd100000000,
        64'd125892541, 64'd158489319, 64'd199526231, 64'd251188643,
        64'd316227766, 64'd398107170, 64'd501187233, 64'd630957344,
        64'd794328234, 64'd1000000000,
        64'd1258925411, 64'd1584893192, 64'd1995262314, 64'd2511886431,
        64'd3162277660, 64'd3981071705, 64'd5011872336, 64'd6309573444,
        64'd7943282347, 64'd10000000000,
        64'd12589254117, 64'd15848931924, 64'd19952623149, 64'd25118864315,
        64'd31622776601, 64'd39810717055, 64'd50118723362, 64'd63095734448,
        64'd79432823472, 64'd100000000000,
        64'd125892541179, 64'd158489319246, 64'd199526231496, 64'd251188643150,
        64'd316227766016, 64'd398107170553, 64'd501187233627, 64'd630957344480,
        64'd794328234724, 64'd1000000000000
    };

endpackage

// File: rtl/lbh_front.sv
`timescale 1ns / 1ps

module lbh_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lbh_pkg::t_cfg                  i_cfg,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_kind,
    input  logic [lbh_pkg::DATA_W-1:0]     i_sample_value,
    input  logic [lbh_pkg::IDX_W-1:0]      i_read_index,
    input  logic                           i_q_full,
    output logic                           o_push,
    output lbh_pkg::t_op                   o_op
);

    logic                                r_s1_valid;
    logic                                r_s1_kind;
    logic [lbh_pkg::DATA_W-1:0]          r_s1_sample;
    logic [lbh_pkg::IDX_W-1:0]           r_s1_index;
    logic [lbh_pkg::MAX_BUCKETS-1:0]     r_s1_therm;
    logic [lbh_pkg::MAX_BUCKETS-1:0]     n_s1_therm;
    logic                                r_s2_valid;
    lbh_pkg::t_op                        r_s2_op;
    lbh_pkg::t_op                        n_s2_op;
    logic                                adv;
    logic [lbh_pkg::IDX_W-1:0]           eff_n;
    logic [lbh_pkg::IDX_W-1:0]           log_count;
    logic [lbh_pkg::IDX_W-1:0]           log_bucket;
    logic [lbh_pkg::IDX_W-1:0]           lin_bucket;
    logic                                use_log;

    // Advance the whole front while the last stage can drain
    assign adv     = !r_s2_valid || !i_q_full;
    assign o_stall = !adv;
    assign o_push  = r_s2_valid && !i_q_full;
    assign o_op    = r_s2_op;

    // Compare the sample against every threshold at once
    always_comb begin
        for (int k = 1; k <= lbh_pkg::MAX_BUCKETS; k++) begin
            n_s1_therm[k-1] = i_sample_value >= lbh_pkg::THRESHOLDS[k];
        end
    end

    // Turn the thermometer code into a count of passed thresholds
    always_comb begin
        log_count = '0;
        for (int k = 1; k <= lbh_pkg::MAX_BUCKETS; k++) begin
            if (r_s1_therm[k-1]) begin
                log_count = lbh_pkg::IDX_W'(k);
            end
        end
    end

    // Pick the bucket for the selected mode
    always_comb begin
        eff_n = (i_cfg.bucket_count > lbh_pkg::IDX_W'(lbh_pkg::MAX_BUCKETS))
              ? lbh_pkg::IDX_W'(lbh_pkg::MAX_BUCKETS) : i_cfg.bucket_count;
        use_log    = i_cfg.log_mode && (eff_n > lbh_pkg::IDX_W'(10));
        log_bucket = (log_count < eff_n) ? log_count : eff_n;
        lin_bucket = ((r_s1_sample[lbh_pkg::DATA_W-1:lbh_pkg::IDX_W] == '0) &&
                      (r_s1_sample[lbh_pkg::IDX_W-1:0] < eff_n))
                   ? r_s1_sample[lbh_pkg::IDX_W-1:0] : eff_n;
        n_s2_op.kind   = r_s1_kind;
        n_s2_op.sample = r_s1_sample;
        if (r_s1_kind == lbh_pkg::KIND_READ) begin
            n_s2_op.bucket = r_s1_index;
        end else if (use_log) begin
            n_s2_op.bucket = log_bucket;
        end else begin
            n_s2_op.bucket = lin_bucket;
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_kind   <= i_kind;
            r_s1_sample <= i_sample_value;
            r_s1_index  <= i_read_index;
            r_s1_therm  <= n_s1_therm;
            r_s2_op     <= n_s2_op;
        end
    end

endmodule

// File: rtl/lbh_queue.sv
`timescale 1ns / 1ps

module lbh_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  lbh_pkg::t_op i_push_op,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output lbh_pkg::t_op o_head
);

    lbh_pkg::t_op                r_slots [lbh_pkg::QUEUE_DEPTH];
    logic [lbh_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [lbh_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [lbh_pkg::QPTR_W:0]    r_count;

    assign o_full  = r_count == (lbh_pkg::QPTR_W+1)'(lbh_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_slots[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + lbh_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + lbh_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (lbh_pkg::QPTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (lbh_pkg::QPTR_W+1)'(1);
            end
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_push_op;
        end
    end

endmodule

// File: rtl/lbh_back.sv
`timescale 1ns / 1ps

module lbh_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  lbh_pkg::t_op               i_head,
    output logic                       o_pop,
    input  logic [lbh_pkg::DATA_W-1:0] i_limit,
    input  logic                       i_clr_over,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [lbh_pkg::IDX_W-1:0]  o_bucket_index,
    output logic [lbh_pkg::DATA_W-1:0] o_bucket_value,
    output logic [lbh_pkg::DATA_W-1:0] o_total_samples,
    output logic [lbh_pkg::DATA_W-1:0] o_running_sum,
    output logic [lbh_pkg::DATA_W-1:0] o_smallest_seen,
    output logic [lbh_pkg::DATA_W-1:0] o_largest_seen,
    output logic [lbh_pkg::DATA_W-1:0] o_over_limit_total
);

    logic [lbh_pkg::DATA_W-1:0]   mem [lbh_pkg::MAX_BUCKETS+1];
    logic [lbh_pkg::MAX_BUCKETS:0] r_vbits;

    logic                         r_b_valid;
    lbh_pkg::t_op                 r_b_op;
    logic                         r_b_oob;
    logic [lbh_pkg::DATA_W-1:0]   r_rd_data;
    logic                         r_rd_vld;
    logic                         r_fwd_hit;
    logic [lbh_pkg::DATA_W-1:0]   r_fwd_val;

    logic                         r_o_valid;
    logic [lbh_pkg::IDX_W-1:0]    r_o_index;
    logic [lbh_pkg::DATA_W-1:0]   r_o_value;

    logic [lbh_pkg::DATA_W-1:0]   r_tally;
    logic [lbh_pkg::DATA_W-1:0]   r_sum;
    logic [lbh_pkg::DATA_W-1:0]   r_min;
    logic [lbh_pkg::DATA_W-1:0]   r_max;
    logic [lbh_pkg::DATA_W-1:0]   r_over;

    logic                         b_fire;
    logic                         b_write;
    logic                         pop_oob;
    logic [lbh_pkg::IDX_W-1:0]    pop_addr;
    logic [lbh_pkg::DATA_W-1:0]   cur_val;
    logic [lbh_pkg::DATA_W-1:0]   new_val;
    logic [lbh_pkg::DATA_W-1:0]   s;

    // Back stage moves when the output register is free or being taken
    assign b_fire  = r_b_valid && (!r_o_valid || !i_stall);
    assign b_write = b_fire && (r_b_op.kind == lbh_pkg::KIND_SAMPLE);
    assign o_pop   = !i_q_empty && (!r_b_valid || b_fire);
    assign s       = r_b_op.sample;

    // Clip the read address to the store
    assign pop_oob  = i_head.bucket > lbh_pkg::IDX_W'(lbh_pkg::MAX_BUCKETS);
    assign pop_addr = pop_oob ? '0 : i_head.bucket;

    // Current counter: bypass a same-cycle write, unwritten entries read zero
    always_comb begin
        if (r_b_oob) begin
            cur_val = '0;
        end else if (r_fwd_hit) begin
            cur_val = r_fwd_val;
        end else if (r_rd_vld) begin
            cur_val = r_rd_data;
        end else begin
            cur_val = '0;
        end
        new_val = cur_val + lbh_pkg::DATA_W'(1);
    end

    // Counter store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (b_write) begin
            mem[r_b_op.bucket] <= new_val;
        end
        if (o_pop) begin
            r_rd_data <= mem[pop_addr];
        end
    end

    // Entry written flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits <= '0;
        end else if (b_write) begin
            r_vbits[r_b_op.bucket] <= 1'b1;
        end
    end

    // Load the back stage with the popped item
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_op    <= i_head;
            r_b_oob   <= pop_oob;
            r_rd_vld  <= r_vbits[pop_addr];
            r_fwd_hit <= b_write && (r_b_op.bucket == pop_addr);
            r_fwd_val <= new_val;
        end
    end

    // Back stage and output valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (b_fire) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_o_index <= r_b_op.bucket;
            r_o_value <= (r_b_op.kind == lbh_pkg::KIND_SAMPLE) ? new_val : cur_val;
        end
    end

    // Running statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
            r_sum   <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_over  <= '0;
        end else begin
            if (b_write) begin
                r_tally <= r_tally + lbh_pkg::DATA_W'(1);
                r_sum   <= r_sum + s;
                if (s < r_min) begin
                    r_min <= s;
                end
                if (s > r_max) begin
                    r_max <= s;
                end
            end
            if (i_clr_over) begin
                r_over <= '0;
            end else if (b_write && (i_limit != '0) && (s > i_limit)) begin
                r_over <= r_over + lbh_pkg::DATA_W'(1);
            end
        end
    end

    assign o_valid            = r_o_valid;
    assign o_bucket_index     = r_o_index;
    assign o_bucket_value     = r_o_value;
    assign o_total_samples    = r_tally;
    assign o_running_sum      = r_sum;
    assign o_smallest_seen    = r_min;
    assign o_largest_seen     = r_max;
    assign o_over_limit_total = r_over;

endmodule

// File: rtl/log_bucket_sample_histogram.sv
`timescale 1ns / 1ps
// Sample histogram with running statistics.
// Input channel (i_valid / o_stall): each item either enters a 64-bit sample
// (i_kind 0) or reads one bucket counter (i_kind 1, i_read_index).
// Output channel (o_valid / i_stall): one result per item, in order, giving
// the bucket index and its counter after the item, plus sample count, sum,
// minimum, maximum and over-limit count.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 log mode,
// 1 bucket count, 2 sample limit (also clears the over-limit count).
// Throughput: one item per cycle while the receiver does not stall. Each item
// passes two front stages (threshold compare, bucket encode), the queue, then
// the counter store read and the increment/write-back stage.
// The counter store is a 121-entry memory with one read and one write port;
// back-to-back hits to the same bucket are bypassed.
// Reset (i_rst_n low, synchronous) empties the pipeline, zeroes statistics,
// sets the minimum to all ones and marks every counter as zero at once.
// When the receiver stalls, the result holds and the four-entry queue fills;
// o_stall rises once the queue is full and an item waits in the last front
// stage.

module log_bucket_sample_histogram (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lbh_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lbh_pkg::DATA_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_kind,
    input  logic [lbh_pkg::DATA_W-1:0]          i_sample_value,
    input  logic [lbh_pkg::IDX_W-1:0]           i_read_index,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [lbh_pkg::IDX_W-1:0]           o_bucket_index,
    output logic [lbh_pkg::DATA_W-1:0]          o_bucket_value,
    output logic [lbh_pkg::DATA_W-1:0]          o_total_samples,
    output logic [lbh_pkg::DATA_W-1:0]          o_running_sum,
    output logic [lbh_pkg::DATA_W-1:0]          o_smallest_seen,
    output logic [lbh_pkg::DATA_W-1:0]          o_largest_seen,
    output logic [lbh_pkg::DATA_W-1:0]          o_over_limit_total
);

    lbh_pkg::t_cfg               r_cfg;
    logic [lbh_pkg::DATA_W-1:0]  r_limit;
    logic                        clr_over;
    logic                        q_full;
    logic                        q_empty;
    logic                        q_push;
    logic                        q_pop;
    lbh_pkg::t_op                push_op;
    lbh_pkg::t_op                head_op;

    assign o_cfg_ready = 1'b1;
    assign clr_over    = i_cfg_valid && (i_cfg_index == lbh_pkg::CFG_SAMPLE_LIMIT);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= '0;
            r_limit <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lbh_pkg::CFG_LOG_MODE: begin
                    r_cfg.log_mode <= i_cfg_data[0];
                end
                lbh_pkg::CFG_BUCKET_COUNT: begin
                    r_cfg.bucket_count <= i_cfg_data[lbh_pkg::IDX_W-1:0];
                end
                lbh_pkg::CFG_SAMPLE_LIMIT: begin
                    r_limit <= i_cfg_data;
                end
                default: begin
                    r_limit <= r_limit;
                end
            endcase
        end
    end

    lbh_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_sample_value (i_sample_value),
        .i_read_index   (i_read_index),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_op           (push_op)
    );

    lbh_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_push_op (push_op),
        .o_full    (q_full),
        .i_pop     (q_pop),
        .o_empty   (q_empty),
        .o_head    (head_op)
    );

    lbh_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_empty          (q_empty),
        .i_head             (head_op),
        .o_pop              (q_pop),
        .i_limit            (r_limit),
        .i_clr_over         (clr_over),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_bucket_index     (o_bucket_index),
        .o_bucket_value     (o_bucket_value),
        .o_total_samples    (o_total_samples),
        .o_running_sum      (o_running_sum),
        .o_smallest_seen    (o_smallest_seen),
        .o_largest_seen     (o_largest_seen),
        .o_over_limit_total (o_over_limit_total)
    );

endmodule
